FILE: rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int NUM_ORDERS_DEF      = 11;
  localparam int MIN_BLOCK_SHIFT_DEF = 10;
  localparam int ORD_W               = 4;
  localparam int SIZE_W              = 21;
  localparam int ADDR_W              = 20;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [ORD_W-1:0]  granted_order;
    logic [SIZE_W-1:0] reported_size;
  } out_t;

  typedef struct packed {
    logic              start;
    logic              taken;
    logic [ORD_W-1:0]  order;
    logic [SIZE_W-1:0] req;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   [15:0] waddr;
    entry_t wdata;
    logic   [15:0] raddr;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SPLIT,
    S_LOOK,
    S_MRG_RD,
    S_MRG_CHK,
    S_MRG_LO,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/buddy_block_allocator_core.sv
`default_nettype none
// channel  signals                          payload
// in       in_valid / in_ready / in_data    bba_pkg::in_t  (cmd, request_size, block_address)
// out      out_valid / out_ready / out_data bba_pkg::out_t (status, granted_address, ...)
//
// one transaction at a time; the block table is a single-port-write ram with a registered read
// allocate: a table walk that visits every block start and covers the whole
//   table (up to 2^(NUM_ORDERS-1) blocks), then a split write per split level
// free: decode, lookup, then buddy read, check and merge write per level; a failing buddy
//   check ends merging; query: decode, lookup; bad cmd or addr: decode; idle before next accept
// after reset a clearing pass over all 2^(NUM_ORDERS-1) table entries runs before in_ready rises
// a result waiting on out_ready holds the next finished transaction in the done state
module buddy_block_allocator_core #(
  parameter int NUM_ORDERS      = bba_pkg::NUM_ORDERS_DEF,
  parameter int MIN_BLOCK_SHIFT = bba_pkg::MIN_BLOCK_SHIFT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bba_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bba_pkg::out_t      out_data
);

  localparam int IW = NUM_ORDERS - 1;
  localparam int NBLK = 1 << IW;
  localparam logic [63:0] HEAP = 64'(1) << (MIN_BLOCK_SHIFT + NUM_ORDERS - 1);
  localparam logic [bba_pkg::ORD_W-1:0] TOP = bba_pkg::ORD_W'(NUM_ORDERS - 1);

  bba_pkg::state_t state, state_next;
  bba_pkg::in_t    req;
  bba_pkg::out_t   res;
  bba_pkg::entry_t rdata, bent;
  bba_pkg::mem_ctl_t ctl;

  logic [IW-1:0] clr;
  logic [IW:0]   idx;
  logic          cand_found;
  logic [bba_pkg::ORD_W-1:0] cand_ord, ord_o, j, mo;
  logic [IW-1:0] cand_idx, k, b;

  logic [bba_pkg::ORD_W-1:0] size_ord, walk_ord, look_ord;
  logic [63:0]   size64, addr64;
  logic          addr_ok, take, walk_end, buddy_ok;
  logic [IW:0]   walk_next;
  logic [IW-1:0] split_b, buddy, lo, hi;
  logic [63:0]   blen;
  logic [1:0]    dec_status;

  always_comb begin
    size64 = 64'(req.request_size);
    addr64 = 64'(req.block_address);
    size_ord = TOP;
    for (int o = NUM_ORDERS - 2; o >= 0; o--) begin
      if (size64 <= (64'(1) << (o + MIN_BLOCK_SHIFT))) size_ord = bba_pkg::ORD_W'(o);
    end
    addr_ok = ((addr64 & ((64'(1) << MIN_BLOCK_SHIFT) - 64'(1))) == 64'(0)) &&
              ((addr64 >> MIN_BLOCK_SHIFT) < 64'(NBLK));
    dec_status = bba_pkg::ST_OK;
    if (req.cmd == bba_pkg::CMD_ALLOC) begin
      if (size64 > HEAP) dec_status = bba_pkg::ST_NOSPACE;
    end else if (req.cmd == bba_pkg::CMD_FREE || req.cmd == bba_pkg::CMD_QUERY) begin
      if (!addr_ok) dec_status = bba_pkg::ST_BADADDR;
    end else begin
      dec_status = bba_pkg::ST_BADADDR;
    end
    walk_ord = (rdata.order > TOP) ? '0 : rdata.order;
    take = rdata.start && !rdata.taken && (walk_ord >= ord_o) &&
           (!cand_found || walk_ord < cand_ord);
    walk_next = idx + ((IW+1)'(1) << walk_ord);
    walk_end = (walk_next >= (IW+1)'(NBLK)) || (walk_next < idx);
    split_b = cand_idx + (IW'(1) << (j - 4'd1));
    blen = 64'(1) << (ord_o + MIN_BLOCK_SHIFT);
    look_ord = (rdata.order > TOP) ? TOP : rdata.order;
    buddy = k ^ (IW'(1) << mo);
    buddy_ok = rdata.start && !rdata.taken && (rdata.order == mo);
    lo = (k < b) ? k : b;
    hi = (k < b) ? b : k;
  end

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::S_CLEAR: if (clr == IW'(NBLK - 1)) state_next = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE:  if (in_valid) state_next = bba_pkg::S_DECODE;
      bba_pkg::S_DECODE: begin
        if (req.cmd == bba_pkg::CMD_ALLOC) begin
          state_next = (size64 > HEAP) ? bba_pkg::S_DONE : bba_pkg::S_WALK;
        end else if (req.cmd == bba_pkg::CMD_FREE || req.cmd == bba_pkg::CMD_QUERY) begin
          state_next = addr_ok ? bba_pkg::S_LOOK : bba_pkg::S_DONE;
        end else begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_WALK: begin
        if (walk_end) state_next = (cand_found || take) ? bba_pkg::S_SPLIT : bba_pkg::S_DONE;
      end
      bba_pkg::S_SPLIT: if (j == ord_o) state_next = bba_pkg::S_DONE;
      bba_pkg::S_LOOK: begin
        if (rdata.start && req.cmd == bba_pkg::CMD_FREE && rdata.taken && look_ord < TOP) begin
          state_next = bba_pkg::S_MRG_RD;
        end else begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_MRG_RD:  state_next = bba_pkg::S_MRG_CHK;
      bba_pkg::S_MRG_CHK: state_next = buddy_ok ? bba_pkg::S_MRG_LO : bba_pkg::S_DONE;
      bba_pkg::S_MRG_LO:  state_next = (mo + 4'd1 < TOP) ? bba_pkg::S_MRG_RD : bba_pkg::S_DONE;
      bba_pkg::S_DONE:    if (!out_valid || out_ready) state_next = bba_pkg::S_IDLE;
      default:            state_next = bba_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = (state == bba_pkg::S_IDLE);
    ctl = '0;
    case (state)
      bba_pkg::S_CLEAR: begin
        ctl.we = 1'b1;
        ctl.waddr = 16'(clr);
        if (clr == '0) begin
          ctl.wdata.start = 1'b1;
          ctl.wdata.order = TOP;
        end
      end
      bba_pkg::S_DECODE: begin
        ctl.raddr = (req.cmd == bba_pkg::CMD_ALLOC) ? '0 : 16'(addr64 >> MIN_BLOCK_SHIFT);
      end
      bba_pkg::S_WALK:   ctl.raddr = 16'(walk_next);
      bba_pkg::S_SPLIT: begin
        ctl.we = 1'b1;
        ctl.wdata.start = 1'b1;
        if (j != ord_o) begin
          ctl.waddr = 16'(split_b);
          ctl.wdata.order = j - 4'd1;
        end else begin
          ctl.waddr = 16'(cand_idx);
          ctl.wdata.taken = 1'b1;
          ctl.wdata.order = ord_o;
          ctl.wdata.req = (size64 > blen) ? bba_pkg::SIZE_W'(blen) : req.request_size;
        end
      end
      bba_pkg::S_LOOK: begin
        if (rdata.start && req.cmd == bba_pkg::CMD_FREE && rdata.taken) begin
          ctl.we = 1'b1;
          ctl.waddr = 16'(k);
          ctl.wdata.start = 1'b1;
          ctl.wdata.order = rdata.order;
        end
      end
      bba_pkg::S_MRG_RD:  ctl.raddr = 16'(buddy);
      bba_pkg::S_MRG_CHK: begin
        ctl.we = buddy_ok;
        ctl.waddr = 16'(hi);
      end
      bba_pkg::S_MRG_LO: begin
        ctl.we = 1'b1;
        ctl.waddr = 16'(lo);
        ctl.wdata.start = 1'b1;
        ctl.wdata.order = mo + 4'd1;
        ctl.wdata.req = (lo == b) ? bent.req : '0;
      end
      default: ctl = '0;
    endcase
  end

  bba_table_ram #(.IDX_W(IW)) u_table (
    .clk   (clk),
    .ctl   (ctl),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bba_pkg::S_CLEAR) clr <= clr + IW'(1);
      if (state == bba_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bba_pkg::S_DONE && (!out_valid || out_ready)) out_data <= res;
    case (state)
      bba_pkg::S_IDLE: if (in_valid) req <= in_data;
      bba_pkg::S_DECODE: begin
        res <= '{status: dec_status, default: '0};
        ord_o <= size_ord;
        idx <= '0;
        cand_found <= 1'b0;
        k <= IW'(addr64 >> MIN_BLOCK_SHIFT);
      end
      bba_pkg::S_WALK: begin
        idx <= walk_next;
        if (take) begin
          cand_found <= 1'b1;
          cand_ord <= walk_ord;
          cand_idx <= idx[IW-1:0];
          j <= walk_ord;
        end else begin
          j <= cand_ord;
        end
        if (walk_end && !(cand_found || take)) res.status <= bba_pkg::ST_NOSPACE;
      end
      bba_pkg::S_SPLIT: begin
        if (j != ord_o) begin
          j <= j - 4'd1;
        end else begin
          res.granted_address <= bba_pkg::ADDR_W'(64'(cand_idx) << MIN_BLOCK_SHIFT);
          res.granted_order <= ord_o;
        end
      end
      bba_pkg::S_LOOK: begin
        mo <= look_ord;
        if (!rdata.start) begin
          res.status <= bba_pkg::ST_BADADDR;
        end else if (req.cmd == bba_pkg::CMD_QUERY) begin
          res.reported_size <= rdata.taken ? rdata.req : '0;
        end else if (!rdata.taken) begin
          res.status <= bba_pkg::ST_BADADDR;
        end
      end
      bba_pkg::S_MRG_RD:  b <= buddy;
      bba_pkg::S_MRG_CHK: bent <= rdata;
      bba_pkg::S_MRG_LO: begin
        k <= lo;
        mo <= mo + 4'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/bba_table_ram.sv
`default_nettype none
module bba_table_ram #(
  parameter int IDX_W = bba_pkg::NUM_ORDERS_DEF - 1
) (
  input  wire logic            clk,
  input  wire bba_pkg::mem_ctl_t ctl,
  output bba_pkg::entry_t      rdata
);

  localparam int DEPTH = 1 << IDX_W;

  bba_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr[IDX_W-1:0]] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr[IDX_W-1:0]];
  end

endmodule
`default_nettype wire
